FILE: rtl/mlpq_pkg.sv
// shared types and constants for the multi-level priority queue
// no dependencies
package mlpq_pkg;

    localparam int LVL_W    = 3;
    localparam int ELEM_W   = 32;
    localparam int PRIO_W   = 4;
    localparam int LCNT_W   = 5;
    localparam int LVLCFG_W = 4;
    localparam int DEPCFG_W = 5;
    localparam int CFG_AW   = 3;
    localparam int APB_DW   = 32;

    // priority value that asks for the default level selection
    localparam logic signed [PRIO_W-1:0] PRIO_DEFAULT = PRIO_W'(-1);

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_BAD_PRIO     = 3'd1,
        ST_ZERO_ELEM    = 3'd2,
        ST_PRIO_IN_FIFO = 3'd3,
        ST_PRIO_MISSING = 3'd4,
        ST_EMPTY        = 3'd5,
        ST_FULL         = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        CMD_ERR,
        CMD_PUSH,
        CMD_POP,
        CMD_POP_ANY
    } t_cmd_kind;

    typedef enum logic {
        REG_LEVELS = 1'b0,
        REG_DEPTH  = 1'b1
    } t_reg_idx;

    typedef struct packed {
        t_cmd_kind          kind;
        t_status            status;
        logic [LVL_W-1:0]   level;
        logic [ELEM_W-1:0]  element;
    } t_cmd;

endpackage

FILE: rtl/mlpq_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module mlpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/mlpq_front.sv
// request classifier: checks priority, element and mode, picks the level
// depends on mlpq_pkg
module mlpq_front import mlpq_pkg::*; (
    input  logic                       i_req_type,
    input  logic signed [ELEM_W-1:0]   i_element,
    input  logic signed [PRIO_W-1:0]   i_priority_req,
    input  logic [LVLCFG_W-1:0]        i_levels,
    output t_cmd                       o_cmd
);

    logic is_default;
    logic bad_prio;
    logic fifo_mode;

    always_comb begin
        is_default = (i_priority_req == PRIO_DEFAULT);
        fifo_mode  = (i_levels == LVLCFG_W'(1));
        // below -1, or at or above the level count
        bad_prio   = (i_priority_req[PRIO_W-1] && !is_default) ||
                     (!i_priority_req[PRIO_W-1] &&
                      ({1'b0, i_priority_req[PRIO_W-2:0]} >= i_levels));

        o_cmd.kind    = CMD_ERR;
        o_cmd.status  = ST_OK;
        o_cmd.level   = i_priority_req[LVL_W-1:0];
        o_cmd.element = i_element;

        if (bad_prio) begin
            o_cmd.status = ST_BAD_PRIO;
        end else if (!i_req_type) begin
            if (i_element == '0) begin
                o_cmd.status = ST_ZERO_ELEM;
            end else if (is_default && !fifo_mode) begin
                o_cmd.status = ST_PRIO_MISSING;
            end else begin
                o_cmd.kind = CMD_PUSH;
                if (is_default) begin
                    o_cmd.level = '0;
                end
            end
        end else begin
            if (fifo_mode && !is_default) begin
                o_cmd.status = ST_PRIO_IN_FIFO;
            end else if (fifo_mode) begin
                o_cmd.kind  = CMD_POP;
                o_cmd.level = '0;
            end else if (is_default) begin
                o_cmd.kind  = CMD_POP_ANY;
                o_cmd.level = '0;
            end else begin
                o_cmd.kind = CMD_POP;
            end
        end
    end

endmodule

FILE: rtl/mlpq_cmdq.sv
// two-entry command queue between classifier and queue engine
// depends on mlpq_pkg
module mlpq_cmdq import mlpq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty,
    output logic o_full
);

    t_cmd       r_slot [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_fill, n_fill;

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ i_push;
        n_rd_ptr = r_rd_ptr ^ i_pop;
        n_fill   = r_fill + 2'(i_push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_cmd   = r_slot[r_rd_ptr];
    assign o_empty = (r_fill == 2'd0);
    assign o_full  = (r_fill == 2'd2);

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full && !i_pop |-> !i_push)
        else $error("command queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("command queue underflow");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill != 2'd3)
        else $error("command queue fill out of range");

endmodule

FILE: rtl/mlpq_back.sv
// queue engine: per-level ring pointers and counts, entry ram, result register
// depends on mlpq_pkg and mlpq_ram
module mlpq_back import mlpq_pkg::*; #(
    parameter int MAX_LEVELS = 8,
    parameter int MAX_DEPTH  = 16,
    localparam int CW = $clog2(MAX_DEPTH + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_clear,
    input  logic [CW-1:0]             i_depth,
    input  logic                      i_cmd_valid,
    input  t_cmd                      i_cmd,
    output logic                      o_cmd_pop,
    output logic                      o_valid,
    output logic [2:0]                o_status,
    output logic signed [ELEM_W-1:0]  o_data_out,
    output logic [LVL_W-1:0]          o_level_used,
    output logic [LCNT_W-1:0]         o_level_count
);

    localparam int LW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int PW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int RAM_DEPTH = MAX_LEVELS * MAX_DEPTH;
    localparam int AW = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

    logic [PW-1:0] r_head  [MAX_LEVELS];
    logic [PW-1:0] n_head  [MAX_LEVELS];
    logic [PW-1:0] r_tail  [MAX_LEVELS];
    logic [PW-1:0] n_tail  [MAX_LEVELS];
    logic [CW-1:0] r_count [MAX_LEVELS];
    logic [CW-1:0] n_count [MAX_LEVELS];

    logic              r_valid, n_valid;
    t_status           r_status, n_status;
    logic [LVL_W-1:0]  r_level, n_level;
    logic [LCNT_W-1:0] r_lcount, n_lcount;
    logic              r_sel_ram, n_sel_ram;

    logic [LW-1:0]     search_idx;
    logic [LW-1:0]     lvl_idx;
    logic [CW-1:0]     cur_count;
    logic [PW-1:0]     cur_head;
    logic [PW-1:0]     cur_tail;
    logic [CW-1:0]     head_p1;
    logic [CW-1:0]     tail_p1;
    logic [AW-1:0]     lvl_base;
    logic              ram_we;
    logic              ram_re;
    logic [AW-1:0]     ram_waddr;
    logic [AW-1:0]     ram_raddr;
    logic [ELEM_W-1:0] ram_rdata;

    // lowest-numbered level that holds something, level 0 when none does
    always_comb begin
        search_idx = '0;
        for (int i = MAX_LEVELS - 1; i >= 0; i--) begin
            if (r_count[i] != '0) begin
                search_idx = LW'(i);
            end
        end
    end

    always_comb begin
        lvl_idx   = (i_cmd.kind == CMD_POP_ANY) ? search_idx : LW'(i_cmd.level);
        cur_count = r_count[lvl_idx];
        cur_head  = r_head[lvl_idx];
        cur_tail  = r_tail[lvl_idx];
        head_p1   = CW'(cur_head) + CW'(1);
        tail_p1   = CW'(cur_tail) + CW'(1);
        lvl_base  = AW'(lvl_idx * MAX_DEPTH);
        ram_waddr = lvl_base + AW'(cur_tail);
        ram_raddr = lvl_base + AW'(cur_head);
    end

    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_valid   = 1'b0;
        n_status  = ST_OK;
        n_level   = '0;
        n_lcount  = '0;
        n_sel_ram = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;

        if (i_cmd_valid) begin
            n_valid = 1'b1;
            unique case (i_cmd.kind)
                CMD_ERR: begin
                    n_status = i_cmd.status;
                end
                CMD_PUSH: begin
                    n_level = LVL_W'(lvl_idx);
                    if (cur_count >= i_depth) begin
                        n_status = ST_FULL;
                        n_lcount = LCNT_W'(cur_count);
                    end else begin
                        ram_we           = 1'b1;
                        n_tail[lvl_idx]  = (tail_p1 >= i_depth) ? '0 : PW'(tail_p1);
                        n_count[lvl_idx] = cur_count + CW'(1);
                        n_lcount         = LCNT_W'(cur_count + CW'(1));
                    end
                end
                CMD_POP, CMD_POP_ANY: begin
                    n_level = LVL_W'(lvl_idx);
                    if (cur_count == '0) begin
                        n_status = ST_EMPTY;
                    end else begin
                        ram_re           = 1'b1;
                        n_sel_ram        = 1'b1;
                        n_head[lvl_idx]  = (head_p1 >= i_depth) ? '0 : PW'(head_p1);
                        n_count[lvl_idx] = cur_count - CW'(1);
                        n_lcount         = LCNT_W'(cur_count - CW'(1));
                    end
                end
                default: begin
                    n_status = i_cmd.status;
                end
            endcase
        end

        // a register write empties every level
        if (i_clear) begin
            for (int i = 0; i < MAX_LEVELS; i++) begin
                n_head[i]  = '0;
                n_tail[i]  = '0;
                n_count[i] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_LEVELS; i++) begin
                r_head[i]  <= '0;
                r_tail[i]  <= '0;
                r_count[i] <= '0;
            end
            r_valid   <= 1'b0;
            r_sel_ram <= 1'b0;
        end else begin
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_count   <= n_count;
            r_valid   <= n_valid;
            r_sel_ram <= n_sel_ram;
        end
        r_status <= n_status;
        r_level  <= n_level;
        r_lcount <= n_lcount;
    end

    mlpq_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_cmd.element),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_cmd_pop     = i_cmd_valid;
    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_data_out    = r_sel_ram ? ram_rdata : '0;
    assign o_level_used  = r_level;
    assign o_level_count = r_lcount;

    for (genvar g = 0; g < MAX_LEVELS; g++) begin : g_lvl_chk
        a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            r_count[g] <= i_depth)
            else $error("level count above ring depth");

        a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            i_clear |=> r_count[g] == '0 && r_head[g] == '0 && r_tail[g] == '0)
            else $error("level not emptied by register write");
    end

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_status == ST_FULL |-> r_lcount == LCNT_W'(i_depth))
        else $error("full status without a full level");

    a_data_only_on_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sel_ram |-> r_valid && r_status == ST_OK)
        else $error("ram data driven on a result that is not a successful pop");

endmodule

FILE: rtl/multi_level_priority_queue.sv
// multi-level priority fifo queue: one ring per level in a shared entry ram
// a request's result strobes on o_valid once it has passed the command queue slot and the result register
// throughput: one request per cycle; the engine does at most one ram access per request
// busy rises only if the two-entry command queue fills, which never happens here
// reset (i_rst_n low, synchronous): all levels empty, one level, ring depth 16
// depends on mlpq_pkg, mlpq_front, mlpq_cmdq, mlpq_back, mlpq_ram
module multi_level_priority_queue import mlpq_pkg::*; #(
    parameter int MAX_LEVELS = 8,
    parameter int MAX_DEPTH  = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_req_type,
    input  logic signed [ELEM_W-1:0]  i_element,
    input  logic signed [PRIO_W-1:0]  i_priority_req,
    output logic                      o_valid,
    output logic [2:0]                o_status,
    output logic signed [ELEM_W-1:0]  o_data_out,
    output logic [LVL_W-1:0]          o_level_used,
    output logic [LCNT_W-1:0]         o_level_count,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [CFG_AW-1:0]         paddr,
    input  logic [APB_DW-1:0]         pwdata,
    output logic [APB_DW-1:0]         prdata,
    output logic                      pready
);

    localparam int CW = $clog2(MAX_DEPTH + 1);

    logic [LVLCFG_W-1:0] r_levels;
    logic [DEPCFG_W-1:0] r_depth;
    logic                cfg_wr;
    t_reg_idx            reg_idx;
    logic [LVLCFG_W-1:0] eff_levels;
    logic [CW-1:0]       eff_depth;

    t_cmd front_cmd;
    t_cmd q_cmd;
    logic q_empty;
    logic q_full;
    logic q_pop;
    logic accept;

    assign reg_idx = t_reg_idx'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_levels <= LVLCFG_W'(1);
            r_depth  <= DEPCFG_W'(16);
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_LEVELS: r_levels <= pwdata[LVLCFG_W-1:0];
                REG_DEPTH:  r_depth  <= pwdata[DEPCFG_W-1:0];
                default:    r_levels <= r_levels;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_LEVELS: prdata = APB_DW'(r_levels);
            REG_DEPTH:  prdata = APB_DW'(r_depth);
            default:    prdata = '0;
        endcase
    end

    // out-of-range register values clamp to 1..max
    always_comb begin
        if (r_levels == '0) begin
            eff_levels = LVLCFG_W'(1);
        end else if (32'(r_levels) > MAX_LEVELS) begin
            eff_levels = LVLCFG_W'(MAX_LEVELS);
        end else begin
            eff_levels = r_levels;
        end

        if (r_depth == '0) begin
            eff_depth = CW'(1);
        end else if (32'(r_depth) > MAX_DEPTH) begin
            eff_depth = CW'(MAX_DEPTH);
        end else begin
            eff_depth = CW'(r_depth);
        end
    end

    assign busy   = q_full;
    assign accept = start && !busy;

    mlpq_front u_front (
        .i_req_type     (i_req_type),
        .i_element      (i_element),
        .i_priority_req (i_priority_req),
        .i_levels       (eff_levels),
        .o_cmd          (front_cmd)
    );

    mlpq_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    mlpq_back #(
        .MAX_LEVELS (MAX_LEVELS),
        .MAX_DEPTH  (MAX_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_clear       (cfg_wr),
        .i_depth       (eff_depth),
        .i_cmd_valid   (!q_empty),
        .i_cmd         (q_cmd),
        .o_cmd_pop     (q_pop),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_data_out    (o_data_out),
        .o_level_used  (o_level_used),
        .o_level_count (o_level_count)
    );

endmodule
